// File: rtl/crcsv_pkg.sv
// ============================================================================
// crcsv_pkg
// Shared types, constants and CRC helpers for the record seal/verify block.
// ============================================================================
package crcsv_pkg;

    // Record framing constants
    localparam logic [31:0] MAGIC_WORD = 32'h55AA_55AA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] MIN_LENGTH = 16'd6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_RECORD_LENGTH = 2'd0;
    localparam t_cfg_idx REG_SEAL_MODE     = 2'd1;

    // Configuration register contents
    typedef struct packed {
        logic [15:0] record_length;
        logic        seal_mode;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_record;
        logic       magic_ok;
        logic       crc_ok;
        logic       record_ok;
    } t_result;

    // Advance a reflected CRC-16/MODBUS by one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Magic byte expected at a header position (little-endian)
    function automatic logic [7:0] magic_byte(input logic [1:0] sel);
        logic [31:0] w;
        w = MAGIC_WORD >> {sel, 3'b000};
        return w[7:0];
    endfunction

endpackage

// File: rtl/config_record_seal_and_verify.sv
// ============================================================================
// config_record_seal_and_verify
// Streams a configuration record, checking or inserting magic and CRC-16.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_data_byte) takes one record
//   byte per word, in address order. Output channel (o_out_valid /
//   i_out_ready) returns one word per input byte: the echoed or sealed
//   byte; the last adds end-of-record and magic flags, plus CRC and record
//   verdicts in verify mode. Configuration channel (i_cfg_valid /
//   o_cfg_ready) writes record_length (index 0) and seal_mode (index 1);
//   it is always ready. Write it only while no byte is in flight.
//   A byte accepted into the input register moves on to the result register,
//   and so to the output, once the result stage is free.
//   Throughput: one byte per cycle while the receiver takes each word; the
//   eight-bit CRC update is unrolled between the input and result registers.
//   Reset clears both stages, the record state (position 0, CRC FFFF) and
//   the registers (length 6, verify mode). A stalled receiver holds the
//   result register; one more byte waits in the input register, then
//   o_in_ready drops.
// ============================================================================
module config_record_seal_and_verify
    import crcsv_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  t_cfg_idx       i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_data_byte,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_end_of_record,
    output logic           o_magic_ok,
    output logic           o_crc_ok,
    output logic           o_record_ok
);

    t_cfg       cfg;
    t_result    step_res;
    logic       out_free;
    logic       advance;
    logic       in_fire;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    assign o_cfg_ready = 1'b1;

    crcsv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    crcsv_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (step_res)
    );

    // Handshake between the two register stages
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input register: hold the byte until the result stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Result register: load on advance, drop once the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out.out_byte;
    assign o_end_of_record = r_out.end_of_record;
    assign o_magic_ok      = r_out.magic_ok;
    assign o_crc_ok        = r_out.crc_ok;
    assign o_record_ok     = r_out.record_ok;

`ifndef NO_ASSERTIONS
    // Verdict flags appear only on the last word of a record
    a_flags_on_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_magic_ok || o_crc_ok || o_record_ok)) |-> o_end_of_record)
        else $error("verdict flag outside end of record");

    // Record verdict is the conjunction of magic and CRC checks
    a_record_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_ok) |-> (o_magic_ok && o_crc_ok))
        else $error("record_ok without magic_ok and crc_ok");

    // A stalled input stage never accepts another byte
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are full");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule

// File: rtl/crcsv_cfg.sv
// ============================================================================
// crcsv_cfg
// Configuration registers: record length and seal mode.
// ============================================================================
module crcsv_cfg
    import crcsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_cfg_idx    i_index,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_length <= MIN_LENGTH;
            r_cfg.seal_mode     <= 1'b0;
        end else if (i_wr) begin
            case (i_index)
                REG_RECORD_LENGTH: r_cfg.record_length <= i_data;
                REG_SEAL_MODE:     r_cfg.seal_mode     <= i_data[0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/crcsv_track.sv
// ============================================================================
// crcsv_track
// Per-record state and the combinational byte step: magic check, CRC update,
// seal substitution and end-of-record verdict.
// ============================================================================
module crcsv_track
    import crcsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    logic [15:0] r_pos;
    logic [15:0] r_crc;
    logic        r_mismatch;
    logic [7:0]  r_stored_lo;

    logic [15:0] n_pos;
    logic [15:0] n_crc;
    logic        n_mismatch;
    logic [7:0]  n_stored_lo;

    logic [15:0] len;
    logic [15:0] last_pos;
    logic        in_header;
    logic        mismatch;
    logic [7:0]  ob;
    t_result     res;

    // Clamp the length and locate the record's last position
    assign len       = (i_cfg.record_length < MIN_LENGTH) ? MIN_LENGTH
                                                          : i_cfg.record_length;
    assign last_pos  = len - 16'd1;
    assign in_header = (r_pos[15:2] == 14'd0);
    assign mismatch  = r_mismatch |
                       (in_header && (i_byte != magic_byte(r_pos[1:0])));

    // Form the result and the next record state
    always_comb begin
        ob          = i_byte;
        res         = '0;
        n_pos       = r_pos + 16'd1;
        n_crc       = r_crc;
        n_mismatch  = mismatch;
        n_stored_lo = r_stored_lo;
        if (r_pos >= last_pos) begin
            res.end_of_record = 1'b1;
            res.magic_ok      = !mismatch;
            if (i_cfg.seal_mode) begin
                ob = r_crc[15:8];
            end else begin
                res.crc_ok    = ({i_byte, r_stored_lo} == r_crc);
                res.record_ok = !mismatch && ({i_byte, r_stored_lo} == r_crc);
            end
            n_pos       = '0;
            n_crc       = CRC_INIT;
            n_mismatch  = 1'b0;
            n_stored_lo = '0;
        end else if (r_pos == last_pos - 16'd1) begin
            n_stored_lo = i_byte;
            if (i_cfg.seal_mode) begin
                ob = r_crc[7:0];
            end
        end else begin
            if (i_cfg.seal_mode && in_header) begin
                ob = magic_byte(r_pos[1:0]);
            end
            n_crc = crc_byte(r_crc, ob);
        end
        res.out_byte = ob;
    end

    // Advance the record state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_mismatch  <= 1'b0;
            r_stored_lo <= '0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_mismatch  <= n_mismatch;
            r_stored_lo <= n_stored_lo;
        end
    end

    assign o_result = res;

endmodule
